@@ design/isps_pkg.sv @@
// Shared types and constants for the I2S prescaler search unit.
// Used by isps_serial_div and i2s_prescaler_search_unit; no dependencies.
package isps_pkg;

   // Field widths
   localparam int unsigned CLK_W  = 30;   // kernel clock register
   localparam int unsigned RATE_W = 24;   // requested word-select rate
   localparam int unsigned DIV_W  = 8;    // integer prescaler
   localparam int unsigned DVS_W  = DIV_W + 1;  // full divisor {div, odd}
   localparam int unsigned QUO_W  = CLK_W - 5;  // clock / 32
   localparam int unsigned ERR_W  = QUO_W;
   localparam int unsigned CNT_W  = $clog2(QUO_W);

   localparam logic [CLK_W-1:0] KCLK_RESET = CLK_W'(137500000);
   localparam logic [DIV_W-1:0] DIV_MAX    = DIV_W'(255);
   localparam logic [DIV_W-1:0] DIV_MIN    = DIV_W'(1);

   // Request to the shared divider
   typedef struct packed {
      logic             start;
      logic [QUO_W-1:0] dividend;
      logic [DVS_W-1:0] divisor;
   } div_req_type;

   // Status back from the shared divider
   typedef struct packed {
      logic             done;
      logic [QUO_W-1:0] quotient;
   } div_rsp_type;

endpackage

@@ design/i2s_prescaler_search_unit.sv @@
// Searches up to 510 candidate divisors per request word, stopping early on an exact
// match. One request word at a time; each candidate is a serial division, a wait in
// S_DIV for the divider's done and a scoring step in S_EVAL. A finished result sits in an
// output register, so the next request can be taken while it waits. Reset (synchronous,
// active high) clears control state and loads the kernel clock register with 137500000.
module i2s_prescaler_search_unit (
   input  logic                        clock,
   input  logic                        reset,
   // request channel
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [isps_pkg::RATE_W-1:0] req_sample_rate,
   input  logic                        req_wide_channel,
   // response channel
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [isps_pkg::DIV_W-1:0]  rsp_divider_int,
   output logic                        rsp_odd_bit,
   // kernel clock register
   input  logic                        csr_wr_en,
   input  logic [isps_pkg::CLK_W-1:0]  csr_wr_data
);

   // Sequencer: one-hot
   typedef enum logic [3:0] {
      S_IDLE = 4'b0001,   // waiting for a request word
      S_DIV  = 4'b0010,   // divider running on current candidate
      S_EVAL = 4'b0100,   // score candidate, launch next
      S_DONE = 4'b1000    // search over, hand result to output register
   } state_type;

   state_type                  state_ff, state_in;

   logic [isps_pkg::CLK_W-1:0]  kclk_ff, kclk_in;
   logic [isps_pkg::QUO_W-1:0]  dvd_ff, dvd_in;     // clock / (32 or 64)
   logic [isps_pkg::RATE_W-1:0] rate_ff, rate_in;
   logic [isps_pkg::DIV_W-1:0]  div_ff, div_in;     // current candidate
   logic                        odd_ff, odd_in;
   logic [isps_pkg::DIV_W-1:0]  best_div_ff, best_div_in;
   logic                        best_odd_ff, best_odd_in;
   logic [isps_pkg::ERR_W-1:0]  min_err_ff, min_err_in;

   logic                        rsp_valid_ff, rsp_valid_in;
   logic [isps_pkg::DIV_W-1:0]  rsp_div_ff, rsp_div_in;
   logic                        rsp_odd_ff, rsp_odd_in;

   isps_pkg::div_req_type       div_req;
   isps_pkg::div_rsp_type       div_rsp;

   logic                        req_take;
   logic                        out_free;
   logic [isps_pkg::ERR_W-1:0]  rate_ext;
   logic [isps_pkg::ERR_W-1:0]  err;
   logic                        last_cand;

   assign req_ready = (state_ff == S_IDLE);
   assign req_take  = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   // absolute error of the achieved rate; clock/32 is below 2^25 so no overflow
   assign rate_ext  = isps_pkg::ERR_W'(rate_ff);
   assign err       = (div_rsp.quotient > rate_ext) ? (div_rsp.quotient - rate_ext)
                                                    : (rate_ext - div_rsp.quotient);
   assign last_cand = (div_ff == isps_pkg::DIV_MAX) && odd_ff;

   always_comb begin
      state_in      = state_ff;
      kclk_in       = kclk_ff;
      dvd_in        = dvd_ff;
      rate_in       = rate_ff;
      div_in        = div_ff;
      odd_in        = odd_ff;
      best_div_in   = best_div_ff;
      best_odd_in   = best_odd_ff;
      min_err_in    = min_err_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_div_in    = rsp_div_ff;
      rsp_odd_in    = rsp_odd_ff;
      div_req.start = 1'b0;

      if (csr_wr_en) begin
         kclk_in = csr_wr_data;
      end

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               // floor(floor(clk/32w)/d) == floor(clk/(32w*d))
               if (req_wide_channel) begin
                  dvd_in = isps_pkg::QUO_W'(kclk_ff >> 6);
               end else begin
                  dvd_in = isps_pkg::QUO_W'(kclk_ff >> 5);
               end
               rate_in       = req_sample_rate;
               div_in        = isps_pkg::DIV_MIN;
               odd_in        = 1'b0;
               best_div_in   = isps_pkg::DIV_MIN;
               best_odd_in   = 1'b0;
               min_err_in    = '1;   // above any reachable error
               // first candidate goes straight to the divider
               div_req.start = 1'b1;
               state_in      = S_DIV;
            end
         end
         S_DIV: begin
            if (div_rsp.done) begin
               state_in = S_EVAL;
            end
         end
         S_EVAL: begin
            if (err < min_err_ff) begin
               min_err_in  = err;
               best_div_in = div_ff;
               best_odd_in = odd_ff;
            end
            if (err == '0 || last_cand) begin
               state_in = S_DONE;
            end else begin
               if (odd_ff) begin
                  div_in = div_ff + 1'b1;
                  odd_in = 1'b0;
               end else begin
                  odd_in = 1'b1;
               end
               state_in = S_DIV;
            end
         end
         S_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_div_in   = best_div_ff;
               rsp_odd_in   = best_odd_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // launch the next candidate straight from the scoring cycle
      if (state_ff == S_EVAL && state_in == S_DIV) begin
         div_req.start = 1'b1;
      end

      // divider loads the candidate being launched; 2*div+odd is the concatenation
      div_req.dividend = dvd_in;
      div_req.divisor  = {div_in, odd_in};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         kclk_ff      <= isps_pkg::KCLK_RESET;
         rsp_valid_ff <= 1'b0;
         min_err_ff   <= '1;
      end else begin
         state_ff     <= state_in;
         kclk_ff      <= kclk_in;
         rsp_valid_ff <= rsp_valid_in;
         min_err_ff   <= min_err_in;
      end
      dvd_ff      <= dvd_in;
      rate_ff     <= rate_in;
      div_ff      <= div_in;
      odd_ff      <= odd_in;
      best_div_ff <= best_div_in;
      best_odd_ff <= best_odd_in;
      rsp_div_ff  <= rsp_div_in;
      rsp_odd_ff  <= rsp_odd_in;
   end

   isps_serial_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_divider_int = rsp_div_ff;
   assign rsp_odd_bit     = rsp_odd_ff;

`ifndef SYNTHESIS
   // divider only finishes while the sequencer waits on it
   a_done_in_div: assert property (@(posedge clock) disable iff (reset)
      div_rsp.done |-> state_ff == S_DIV)
      else $error("divider finished outside S_DIV");

   // a request word always leads straight into the search
   a_take_to_div: assert property (@(posedge clock) disable iff (reset)
      req_take |=> state_ff == S_DIV)
      else $error("search did not start after request");

   // candidate never leaves the legal divider range during scoring
   a_cand_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_EVAL |-> div_ff != '0)
      else $error("candidate divider out of range");

   // a finished search never reports a zero divider
   a_best_nonzero: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_DONE |-> best_div_ff != '0)
      else $error("zero divider chosen");
`endif

endmodule

@@ design/isps_serial_div.sv @@
// Restoring serial divider, one quotient bit per cycle.
// Depends on isps_pkg for widths and the request/status structs.
module isps_serial_div (
   input  logic                  clock,
   input  logic                  reset,
   input  isps_pkg::div_req_type div_req,
   output isps_pkg::div_rsp_type div_rsp
);

   logic [isps_pkg::DVS_W-1:0] rem_ff, rem_in;
   logic [isps_pkg::QUO_W-1:0] quo_ff, quo_in;
   logic [isps_pkg::DVS_W-1:0] dvs_ff, dvs_in;
   logic [isps_pkg::CNT_W-1:0] cnt_ff, cnt_in;
   logic                       busy_ff, busy_in;
   logic                       done_ff, done_in;

   logic [isps_pkg::DVS_W:0]   trial;
   logic                       fits;

   // partial remainder with next dividend bit shifted in
   assign trial = {rem_ff, quo_ff[isps_pkg::QUO_W-1]};
   assign fits  = (trial >= {1'b0, dvs_ff});

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (div_req.start) begin
         rem_in  = '0;
         quo_in  = div_req.dividend;
         dvs_in  = div_req.divisor;
         cnt_in  = isps_pkg::CNT_W'(isps_pkg::QUO_W - 1);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (fits) begin
            rem_in = isps_pkg::DVS_W'(trial - {1'b0, dvs_ff});
         end else begin
            rem_in = trial[isps_pkg::DVS_W-1:0];
         end
         quo_in = {quo_ff[isps_pkg::QUO_W-2:0], fits};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = quo_ff;

endmodule
